// File: src/bilevel_rle_nibble_encoder_assert.svh
// Assertion macros shared by the bilevel run-length encoder modules.
// No dependencies; include by bare file name inside a module body.
`ifndef BILEVEL_RLE_NIBBLE_ENCODER_ASSERT_SVH
`define BILEVEL_RLE_NIBBLE_ENCODER_ASSERT_SVH

// cond must never hold out of reset
`define BRE_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

// ante implies cons in the same cycle
`define BRE_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

// File: src/bre_pkg.sv
// Package for the bilevel run-length nibble encoder: run types, constants
// and the command word passed from the front part to the back part.
package bre_pkg;

	localparam int NIBBLE_BITS = 4;
	localparam int CODE_BITS   = 2 * NIBBLE_BITS;
	localparam int CMDQ_DEPTH  = 4;

	typedef logic [NIBBLE_BITS-1:0] run_t;
	typedef logic [CODE_BITS-1:0]   code_t;

	localparam run_t RUN_MAX = {NIBBLE_BITS{1'b1}};

	// one accepted pixel yields a closed pair, a flushed pair, or both
	typedef struct packed {
		logic  close_v;
		code_t close_code;
		logic  flush_v;
		code_t flush_code;
	} cmd_t;

endpackage

// File: src/bre_front.sv
// Front part of the bilevel run-length encoder: run counters and pair closing.
// Depends on bre_pkg and bilevel_rle_nibble_encoder_assert.svh.
module bre_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          accept,
	input  logic [7:0]    pixel_value,
	input  logic          last_pixel,
	output logic          cmd_push,
	output bre_pkg::cmd_t cmd
);

	logic          phase_q;
	bre_pkg::run_t white_q;
	bre_pkg::run_t black_q;

	logic          black;
	logic          phase_n;
	bre_pkg::run_t white_n;
	bre_pkg::run_t black_n;
	logic          close_v;

	assign black = |pixel_value;

	always_comb begin
		phase_n = phase_q;
		white_n = white_q;
		black_n = black_q;
		close_v = 1'b0;
		if (!phase_q) begin
			if (black) begin
				phase_n = 1'b1;
				black_n = bre_pkg::run_t'(1);
			end else if (white_q != bre_pkg::RUN_MAX) begin
				white_n = white_q + bre_pkg::run_t'(1);
			end else begin
				close_v = 1'b1;
				white_n = bre_pkg::run_t'(1);
				black_n = '0;
			end
		end else begin
			if (!black) begin
				close_v = 1'b1;
				phase_n = 1'b0;
				white_n = bre_pkg::run_t'(1);
				black_n = '0;
			end else if (black_q != bre_pkg::RUN_MAX) begin
				black_n = black_q + bre_pkg::run_t'(1);
			end else begin
				close_v = 1'b1;
				white_n = '0;
				black_n = bre_pkg::run_t'(1);
			end
		end
	end

	always_comb begin
		cmd.close_v    = close_v;
		cmd.close_code = {white_q, black_q};
		cmd.flush_v    = last_pixel;
		cmd.flush_code = {white_n, black_n};
		cmd_push       = accept && (close_v || last_pixel);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= 1'b0;
			white_q <= '0;
			black_q <= '0;
		end else if (accept) begin
			if (last_pixel) begin
				phase_q <= 1'b0;
				white_q <= '0;
				black_q <= '0;
			end else begin
				phase_q <= phase_n;
				white_q <= white_n;
				black_q <= black_n;
			end
		end
	end

`include "bilevel_rle_nibble_encoder_assert.svh"

	`BRE_ASSERT_IMP(a_flush_nonempty, clk, arst_n, cmd_push && cmd.flush_v, cmd.flush_code != '0, "flushed pair holds no pixel")

endmodule

// File: src/bre_cmdq.sv
// Command queue between the front and back parts of the run-length encoder.
// Depends on bre_pkg and bilevel_rle_nibble_encoder_assert.svh.
module bre_cmdq #(
	parameter int DEPTH = bre_pkg::CMDQ_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  bre_pkg::cmd_t push_cmd,
	output logic          full,
	input  logic          pop,
	output logic          avail,
	output bre_pkg::cmd_t head_cmd
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	bre_pkg::cmd_t      slot_q [DEPTH];
	logic [PTR_W-1:0]   wr_q;
	logic [PTR_W-1:0]   rd_q;
	logic [CNT_W-1:0]   count_q;
	logic               do_push;
	logic               do_pop;

	assign full     = (count_q == CNT_W'(DEPTH));
	assign avail    = (count_q != '0);
	assign head_cmd = slot_q[rd_q];
	assign do_push  = push && !full;
	assign do_pop   = pop && avail;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (!do_push && do_pop) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

`include "bilevel_rle_nibble_encoder_assert.svh"

	`BRE_ASSERT_NEVER(a_no_overflow, clk, arst_n, push && full, "command dropped on full queue")
	`BRE_ASSERT_NEVER(a_count_range, clk, arst_n, count_q > CNT_W'(DEPTH), "queue count out of range")

endmodule

// File: src/bre_back.sv
// Back part of the run-length encoder: expands commands into code words.
// Depends on bre_pkg.
module bre_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_avail,
	input  bre_pkg::cmd_t cmd,
	output logic          cmd_pop,
	output logic          empty,
	input  logic          pop,
	output logic [7:0]    code_byte,
	output logic          last_code
);

	logic                close_v_q;
	logic                flush_v_q;
	bre_pkg::code_t      close_code_q;
	bre_pkg::code_t      flush_code_q;
	logic                fire;

	assign empty     = !(close_v_q || flush_v_q);
	assign fire      = pop && !empty;
	assign code_byte = close_v_q ? close_code_q : flush_code_q;
	assign last_code = !close_v_q;
	assign cmd_pop   = cmd_avail && (empty || (fire && !(close_v_q && flush_v_q)));

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			close_code_q <= cmd.close_code;
			flush_code_q <= cmd.flush_code;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			close_v_q <= 1'b0;
			flush_v_q <= 1'b0;
		end else if (cmd_pop) begin
			close_v_q <= cmd.close_v;
			flush_v_q <= cmd.flush_v;
		end else if (fire) begin
			if (close_v_q) begin
				close_v_q <= 1'b0;
			end else begin
				flush_v_q <= 1'b0;
			end
		end
	end

endmodule

// File: src/bilevel_rle_nibble_encoder.sv
// Top level of the bilevel run-length nibble encoder.
// Depends on bre_pkg, bre_front, bre_cmdq and bre_back.
//
// Takes one pixel per clock while full is low (zero is white, nonzero is
// black) and emits code words holding a white run in the high nibble and a
// black run in the low nibble, runs capped at 15. A pixel with last_pixel
// set flushes the pending pair as a word with last_code set and clears the
// run state. The front counts runs and closes pairs in the cycle a pixel is
// accepted; each pixel that yields words writes one command into a queue of
// QUEUE_DEPTH entries, and the back hands out one word per clock from an
// output register while pop is high and empty is low. A pixel can give two
// words, so under a steady pop full rises only when the queue fills.
module bilevel_rle_nibble_encoder #(
	parameter int QUEUE_DEPTH = bre_pkg::CMDQ_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [7:0] pixel_value,
	input  logic       last_pixel,
	output logic       empty,
	input  logic       pop,
	output logic [7:0] code_byte,
	output logic       last_code
);

	logic          accept;
	logic          cmd_push;
	bre_pkg::cmd_t front_cmd;
	logic          cmd_pop;
	logic          cmd_avail;
	bre_pkg::cmd_t head_cmd;

	assign accept = push && !full;

	bre_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.pixel_value (pixel_value),
		.last_pixel  (last_pixel),
		.cmd_push    (cmd_push),
		.cmd         (front_cmd)
	);

	bre_cmdq #(
		.DEPTH (QUEUE_DEPTH)
	) u_cmdq (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (cmd_push),
		.push_cmd (front_cmd),
		.full     (full),
		.pop      (cmd_pop),
		.avail    (cmd_avail),
		.head_cmd (head_cmd)
	);

	bre_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_avail (cmd_avail),
		.cmd       (head_cmd),
		.cmd_pop   (cmd_pop),
		.empty     (empty),
		.pop       (pop),
		.code_byte (code_byte),
		.last_code (last_code)
	);

endmodule
